[rtl/xtce_pkg.sv]
// Package for the XML tag content extractor.
// Holds byte codes, widths, register indexes and the config struct; no dependencies.
`timescale 1ns / 1ps

package xtce_pkg;

  localparam int TagMaxLenDef = 16;
  localparam int CntW         = 5;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 64;

  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChNl    = 8'h0A;

  localparam logic [CfgIdxW-1:0] RegTagCharsLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTagCharsHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTagLength    = 2'd2;

  localparam logic [CfgDataW-1:0] TagCharsLowRst  = 64'h0000_0000_6E61_654D;
  localparam logic [CfgDataW-1:0] TagCharsHighRst = 64'h0;
  localparam logic [CntW-1:0]     TagLengthRst    = 5'd4;

  typedef struct packed {
    logic [CfgDataW-1:0] chars_low;
    logic [CfgDataW-1:0] chars_high;
    logic [CntW-1:0]     length;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } result_t;

endpackage

[rtl/xtce_parser.sv]
// Parse state machine and incremental start-tag name compare.
// Uses xtce_pkg; one byte per enabled cycle, result is combinational.
`timescale 1ns / 1ps

module xtce_parser
  import xtce_pkg::*;
#(
  parameter int TAG_MAX_LEN = TagMaxLenDef
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] byte_in,
  input  cfg_t       cfg,
  output result_t    result
);

  typedef enum logic [2:0] {
    MODE_OUTSIDE,
    MODE_AFTER_LT,
    MODE_START,
    MODE_END,
    MODE_BODY
  } mode_t;

  mode_t           mode, mode_next;
  logic            match_flag, match_flag_next;
  logic [CntW-1:0] name_count, name_count_next;
  logic            name_mismatch, name_mismatch_next;

  logic [2*CfgDataW-1:0] wanted;
  logic [7:0]            wanted_char;
  logic                  do_start, do_body;

  assign wanted      = {cfg.chars_high, cfg.chars_low};
  assign wanted_char = wanted[{name_count[3:0], 3'b000} +: 8];

  always_comb begin
    mode_next          = mode;
    match_flag_next    = match_flag;
    name_count_next    = name_count;
    name_mismatch_next = name_mismatch;
    do_start           = 1'b0;
    do_body            = 1'b0;
    result             = '0;

    unique case (mode)
      MODE_AFTER_LT: begin
        if (byte_in == ChSlash) begin
          mode_next = MODE_END;
        end else if (byte_in != ChLt) begin
          mode_next = MODE_START;
          do_start  = 1'b1;
        end
      end
      MODE_START: begin
        do_start = 1'b1;
      end
      MODE_END: begin
        if (byte_in == ChGt) begin
          mode_next = MODE_OUTSIDE;
        end
      end
      MODE_BODY: begin
        do_body = 1'b1;
      end
      default: begin
        if (byte_in == ChLt) begin
          mode_next = MODE_AFTER_LT;
        end else if (byte_in != ChNl) begin
          mode_next = MODE_BODY;
          do_body   = 1'b1;
        end
      end
    endcase

    if (do_start) begin
      if (byte_in == ChGt) begin
        if (!name_mismatch && name_count == cfg.length) begin
          match_flag_next = 1'b1;
        end
        name_count_next    = '0;
        name_mismatch_next = 1'b0;
        mode_next          = MODE_OUTSIDE;
      end else if (name_count >= CntW'(TAG_MAX_LEN)) begin
        name_mismatch_next = 1'b1;
      end else begin
        if (name_count >= cfg.length || wanted_char != byte_in) begin
          name_mismatch_next = 1'b1;
        end
        name_count_next = name_count + CntW'(1);
      end
    end

    if (do_body) begin
      if (byte_in == ChLt) begin
        mode_next = MODE_END;
        if (match_flag) begin
          match_flag_next = 1'b0;
          result.valid    = 1'b1;
          result.last     = 1'b1;
        end
      end else if (match_flag) begin
        result.valid = 1'b1;
        result.data  = byte_in;
      end
    end

    if (!step) begin
      result.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_OUTSIDE;
      match_flag    <= 1'b0;
      name_count    <= '0;
      name_mismatch <= 1'b0;
    end else if (step) begin
      mode          <= mode_next;
      match_flag    <= match_flag_next;
      name_count    <= name_count_next;
      name_mismatch <= name_mismatch_next;
    end
  end

endmodule

[rtl/xml_tag_content_extractor.sv]
// XML tag content extractor, top level.
// Depends on xtce_pkg and xtce_parser.
//
// Usage:
//   Input channel in_valid/in_ready/in_byte carries the text stream, one byte per request.
//   Output channel out_valid/out_ready carries content_byte and record_end: body bytes of
//   elements whose start-tag name equals the configured name, then a record_end request
//   (content_byte zero) at the '<' that ends the body. Bytes that give no result vanish.
//   Config port cfg_we/cfg_index/cfg_data writes tag_chars_low (0), tag_chars_high (1)
//   and tag_length (2); write only while the block is idle.
// Timing:
//   A byte is taken into the input register; when the output register is free or being
//   accepted, the parser updates its state and loads the output register with the result
//   at that same edge. Throughput is one byte per cycle while the output does not stall;
//   the parser computes each result combinationally from the byte in the input register.
// Stall:
//   While out_ready is low and a result waits, the input register holds its byte and
//   in_ready drops once it is full; nothing is lost or repeated.
// Reset:
//   rst (synchronous) empties both registers, returns the parser to the outside state
//   and loads the register reset values (name "Mean", length 4).
`timescale 1ns / 1ps

module xml_tag_content_extractor
  import xtce_pkg::*;
#(
  parameter int TAG_MAX_LEN = TagMaxLenDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          content_byte,
  output logic                record_end,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t       cfg;
  logic       in_full;
  logic [7:0] in_data;
  logic       step;
  result_t    result;

  assign step     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chars_low  <= TagCharsLowRst;
      cfg.chars_high <= TagCharsHighRst;
      cfg.length     <= TagLengthRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegTagCharsLow:  cfg.chars_low  <= cfg_data;
        RegTagCharsHigh: cfg.chars_high <= cfg_data;
        RegTagLength:    cfg.length     <= cfg_data[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_data <= in_byte;
    end
  end

  xtce_parser #(
    .TAG_MAX_LEN (TAG_MAX_LEN)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .byte_in (in_data),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= result.valid;
    end
    if (result.valid && (!out_valid || out_ready)) begin
      content_byte <= result.data;
      record_end   <= result.last;
    end
  end

endmodule
